// ----- hw/rtl/nbgf_pkg.sv -----
// Shared constants, types and state codes for the n-body gravity integrator.
// No dependencies; used by nbgf_divroot and nbody_gravity_force_integrator.
package nbgf_pkg;

	localparam int FracBits  = 24;
	localparam int DataW     = 32;
	localparam int CfgW      = 24;
	localparam int AccW      = 48;
	localparam int DsqW      = 44;
	localparam int WideW     = 64;
	localparam int ShW       = WideW + FracBits;
	localparam int RootSteps = (DsqW + FracBits) / 2;
	localparam int DivSteps  = ShW;
	localparam int CntW      = $clog2(DivSteps + 1);

	localparam logic [WideW-1:0] QuotCap = WideW'(1) << 62;
	localparam logic [CfgW-1:0] SoftReset = CfgW'(16777);
	localparam logic [CfgW-1:0] DtReset   = CfgW'(167772);

	typedef enum logic {
		REG_SOFT = 1'b0,
		REG_DT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic is_root;
	} dr_cmd_t;

	typedef enum logic [14:0] {
		S_IDLE      = 15'b000000000000001,
		S_SQ_MUL    = 15'b000000000000010,
		S_SQ_ADD    = 15'b000000000000100,
		S_ROOT_GO   = 15'b000000000001000,
		S_ROOT_WAIT = 15'b000000000010000,
		S_MM_MUL    = 15'b000000000100000,
		S_DIV1_GO   = 15'b000000001000000,
		S_DIV1_WAIT = 15'b000000010000000,
		S_DIV2_GO   = 15'b000000100000000,
		S_DIV2_WAIT = 15'b000001000000000,
		S_ACC       = 15'b000010000000000,
		S_EU_HI     = 15'b000100000000000,
		S_EU_LO     = 15'b001000000000000,
		S_EU_ADD    = 15'b010000000000000,
		S_OUT       = 15'b100000000000000
	} state_t;

endpackage

// ----- hw/rtl/nbody_gravity_force_integrator.sv -----
// Top level: softened direct-sum gravity accumulation and semi-implicit Euler update.
// Depends on nbgf_pkg and nbgf_divroot; one shared 32x32 multiplier.
//
//   channel   signals                        direction
//   input     in_valid/in_ready + fields     request in
//   output    out_valid/out_ready + new_*    request out
//   config    wr_en, wr_index, wr_data       write only
//
// Per source, the shared bit-serial divide/root unit runs a 34-step distance root
// and two 88-step divisions per axis. A last source adds an Euler update on
// the shared multiplier. in_ready is high
// only in idle. A finished result waits in the output register; the next
// request is taken meanwhile, but a second result holds the sequencer in its
// final state until the first one leaves. Reset loads default config and clears the sums.
module nbody_gravity_force_integrator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                first_source,
	input  logic                last_source,
	input  logic signed [31:0]  target_x,
	input  logic signed [31:0]  target_y,
	input  logic signed [31:0]  target_z,
	input  logic signed [31:0]  target_vx,
	input  logic signed [31:0]  target_vy,
	input  logic signed [31:0]  target_vz,
	input  logic signed [31:0]  source_x,
	input  logic signed [31:0]  source_y,
	input  logic signed [31:0]  source_z,
	input  logic [31:0]         source_mass,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  new_vx,
	output logic signed [31:0]  new_vy,
	output logic signed [31:0]  new_vz,
	output logic signed [31:0]  new_x,
	output logic signed [31:0]  new_y,
	output logic signed [31:0]  new_z,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic [23:0]         wr_data
);

	localparam int DW = nbgf_pkg::DataW;
	localparam int AW = nbgf_pkg::AccW;
	localparam int WW = nbgf_pkg::WideW;
	localparam int FB = nbgf_pkg::FracBits;
	localparam int CW = nbgf_pkg::CfgW;

	nbgf_pkg::state_t state_q;
	logic [CW-1:0]    soft_q, dt_q;
	logic [1:0]       axis_q;
	logic [2:0]       eu_q;
	logic             last_q;
	logic             out_valid_q;

	logic signed [DW-1:0] t_q [3];
	logic signed [DW-1:0] tv_q [3];
	logic [DW-1:0]        mag_q [3];
	logic                 neg_q [3];
	logic [DW-1:0]        mass_q;
	logic [nbgf_pkg::DsqW-1:0] dsq_q;
	logic [WW-1:0]        root_q, prod_q, hold_q;
	logic signed [AW-1:0] acc_q [3];
	logic signed [DW-1:0] nv_q [3], np_q [3];
	logic signed [DW-1:0] ov_q [3], op_q [3];

	logic signed [DW-1:0] src [3], tgt [3];
	logic [DW:0]          dif [3];
	logic [DW-1:0]        dmag [3];

	logic [DW-1:0]        mul_a, mul_b;
	logic [nbgf_pkg::DsqW-1:0] dsq_sum;
	logic                 in_acc;

	nbgf_pkg::dr_cmd_t    dr_cmd;
	logic [WW-1:0]        dr_num, dr_den, dr_res;
	logic                 dr_busy;

	logic [1:0]           lane;
	logic signed [AW-1:0] rate;
	logic signed [DW-1:0] base;
	logic                 rate_neg;
	logic [AW-1:0]        rate_mag;
	logic [AW:0]          pmag;
	logic signed [AW+2:0] inc, eu_sum;
	logic signed [DW-1:0] eu_res;
	logic signed [WW+1:0] acc_sum;
	logic signed [AW-1:0] acc_new;

	assign in_ready = state_q == nbgf_pkg::S_IDLE;
	assign in_acc   = in_valid && in_ready;

	assign src[0] = source_x;
	assign src[1] = source_y;
	assign src[2] = source_z;
	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;

	for (genvar g = 0; g < 3; g++) begin : g_diff
		assign dif[g]  = {src[g][DW-1], src[g]} - {tgt[g][DW-1], tgt[g]};
		assign dmag[g] = dif[g][DW] ? DW'(-dif[g]) : dif[g][DW-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			nbgf_pkg::S_SQ_MUL: begin
				mul_a = mag_q[axis_q];
				mul_b = mag_q[axis_q];
			end
			nbgf_pkg::S_MM_MUL: begin
				mul_a = mass_q;
				mul_b = mag_q[axis_q];
			end
			nbgf_pkg::S_EU_HI: begin
				mul_a = DW'(rate_mag[AW-1:CW]);
				mul_b = DW'(dt_q);
			end
			nbgf_pkg::S_EU_LO: begin
				mul_a = DW'(rate_mag[CW-1:0]);
				mul_b = DW'(dt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign dsq_sum = dsq_q + nbgf_pkg::DsqW'(prod_q >> FB);

	always_comb begin
		dr_cmd.start   = 1'b0;
		dr_cmd.is_root = 1'b0;
		dr_num         = '0;
		dr_den         = '0;
		case (state_q)
			nbgf_pkg::S_ROOT_GO: begin
				dr_cmd.start   = 1'b1;
				dr_cmd.is_root = 1'b1;
				dr_num         = WW'(dsq_q);
			end
			nbgf_pkg::S_DIV1_GO: begin
				dr_cmd.start = 1'b1;
				dr_num       = prod_q;
				dr_den       = WW'(dsq_q);
			end
			nbgf_pkg::S_DIV2_GO: begin
				dr_cmd.start = 1'b1;
				dr_num       = dr_res;
				dr_den       = root_q;
			end
			default: begin
				dr_cmd.start = 1'b0;
			end
		endcase
	end

	nbgf_divroot u_divroot (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dr_cmd),
		.num    (dr_num),
		.den    (dr_den),
		.busy   (dr_busy),
		.res    (dr_res)
	);

	// accumulate one axis term, saturating to the accumulator range
	always_comb begin
		if (neg_q[axis_q]) begin
			acc_sum = (WW+2)'(acc_q[axis_q]) - $signed({2'b00, dr_res});
		end else begin
			acc_sum = (WW+2)'(acc_q[axis_q]) + $signed({2'b00, dr_res});
		end
		if (acc_sum > $signed((WW+2)'({1'b0, {(AW-1){1'b1}}}))) begin
			acc_new = {1'b0, {(AW-1){1'b1}}};
		end else if (acc_sum < -((WW+2)'(1) <<< (AW-1))) begin
			acc_new = {1'b1, {(AW-1){1'b0}}};
		end else begin
			acc_new = acc_sum[AW-1:0];
		end
	end

	// Euler step: velocities first, then positions from the new velocities
	always_comb begin
		lane = (eu_q >= 3'd3) ? 2'(eu_q - 3'd3) : eu_q[1:0];
		if (eu_q >= 3'd3) begin
			rate = AW'(nv_q[lane]);
			base = t_q[lane];
		end else begin
			rate = acc_q[lane];
			base = tv_q[lane];
		end
		rate_neg = rate[AW-1];
		rate_mag = rate_neg ? AW'(-rate) : rate;
		pmag     = hold_q[AW:0] + (AW+1)'(prod_q[FB+CW-1:FB]);
		inc      = rate_neg ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});
		eu_sum   = (AW+3)'(base) + inc;
		if (eu_sum > $signed((AW+3)'({1'b0, {(DW-1){1'b1}}}))) begin
			eu_res = {1'b0, {(DW-1){1'b1}}};
		end else if (eu_sum < -((AW+3)'(1) <<< (DW-1))) begin
			eu_res = {1'b1, {(DW-1){1'b0}}};
		end else begin
			eu_res = eu_sum[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nbgf_pkg::S_IDLE;
			soft_q      <= nbgf_pkg::SoftReset;
			dt_q        <= nbgf_pkg::DtReset;
			axis_q      <= '0;
			eu_q        <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (wr_en) begin
				case (nbgf_pkg::reg_idx_t'(wr_index))
					nbgf_pkg::REG_SOFT: soft_q <= wr_data;
					nbgf_pkg::REG_DT:   dt_q   <= wr_data;
					default:            soft_q <= soft_q;
				endcase
			end
			if (state_q == nbgf_pkg::S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				nbgf_pkg::S_IDLE: begin
					if (in_acc) begin
						last_q  <= last_source;
						axis_q  <= '0;
						state_q <= nbgf_pkg::S_SQ_MUL;
						if (first_source) begin
							for (int i = 0; i < 3; i++) begin
								acc_q[i] <= '0;
							end
						end
					end
				end
				nbgf_pkg::S_SQ_MUL: state_q <= nbgf_pkg::S_SQ_ADD;
				nbgf_pkg::S_SQ_ADD: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						eu_q   <= '0;
						if (dsq_sum != '0) begin
							state_q <= nbgf_pkg::S_ROOT_GO;
						end else begin
							state_q <= last_q ? nbgf_pkg::S_EU_HI : nbgf_pkg::S_IDLE;
						end
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= nbgf_pkg::S_SQ_MUL;
					end
				end
				nbgf_pkg::S_ROOT_GO: state_q <= nbgf_pkg::S_ROOT_WAIT;
				nbgf_pkg::S_ROOT_WAIT: begin
					if (!dr_busy) begin
						state_q <= nbgf_pkg::S_MM_MUL;
					end
				end
				nbgf_pkg::S_MM_MUL: state_q <= nbgf_pkg::S_DIV1_GO;
				nbgf_pkg::S_DIV1_GO: state_q <= nbgf_pkg::S_DIV1_WAIT;
				nbgf_pkg::S_DIV1_WAIT: begin
					if (!dr_busy) begin
						state_q <= nbgf_pkg::S_DIV2_GO;
					end
				end
				nbgf_pkg::S_DIV2_GO: state_q <= nbgf_pkg::S_DIV2_WAIT;
				nbgf_pkg::S_DIV2_WAIT: begin
					if (!dr_busy) begin
						state_q <= nbgf_pkg::S_ACC;
					end
				end
				nbgf_pkg::S_ACC: begin
					acc_q[axis_q] <= acc_new;
					if (axis_q == 2'd2) begin
						eu_q    <= '0;
						state_q <= last_q ? nbgf_pkg::S_EU_HI : nbgf_pkg::S_IDLE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= nbgf_pkg::S_MM_MUL;
					end
				end
				nbgf_pkg::S_EU_HI: state_q <= nbgf_pkg::S_EU_LO;
				nbgf_pkg::S_EU_LO: state_q <= nbgf_pkg::S_EU_ADD;
				nbgf_pkg::S_EU_ADD: begin
					if (eu_q == 3'd5) begin
						state_q <= nbgf_pkg::S_OUT;
					end else begin
						eu_q    <= eu_q + 1'b1;
						state_q <= nbgf_pkg::S_EU_HI;
					end
				end
				nbgf_pkg::S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= nbgf_pkg::S_IDLE;
					end
				end
				default: state_q <= nbgf_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mass_q <= source_mass;
			dsq_q  <= nbgf_pkg::DsqW'(soft_q);
			t_q[0] <= target_x;
			t_q[1] <= target_y;
			t_q[2] <= target_z;
			tv_q[0] <= target_vx;
			tv_q[1] <= target_vy;
			tv_q[2] <= target_vz;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= dmag[i];
				neg_q[i] <= dif[i][DW];
			end
		end
		if (state_q == nbgf_pkg::S_SQ_MUL || state_q == nbgf_pkg::S_MM_MUL ||
		    state_q == nbgf_pkg::S_EU_HI || state_q == nbgf_pkg::S_EU_LO) begin
			prod_q <= WW'(mul_a) * WW'(mul_b);
		end
		if (state_q == nbgf_pkg::S_EU_LO) begin
			hold_q <= prod_q;
		end
		if (state_q == nbgf_pkg::S_SQ_ADD) begin
			dsq_q <= dsq_sum;
		end
		if (state_q == nbgf_pkg::S_ROOT_WAIT && !dr_busy) begin
			root_q <= dr_res;
		end
		if (state_q == nbgf_pkg::S_EU_ADD) begin
			if (eu_q >= 3'd3) begin
				np_q[lane] <= eu_res;
			end else begin
				nv_q[lane] <= eu_res;
			end
		end
		if (state_q == nbgf_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			for (int i = 0; i < 3; i++) begin
				ov_q[i] <= nv_q[i];
				op_q[i] <= np_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign new_vx    = ov_q[0];
	assign new_vy    = ov_q[1];
	assign new_vz    = ov_q[2];
	assign new_x     = op_q[0];
	assign new_y     = op_q[1];
	assign new_z     = op_q[2];

	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !dr_busy)
		else $error("request taken while divide/root unit busy");

	a_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dr_busy |-> (state_q == nbgf_pkg::S_ROOT_WAIT || state_q == nbgf_pkg::S_DIV1_WAIT ||
		             state_q == nbgf_pkg::S_DIV2_WAIT))
		else $error("divide/root unit busy outside a wait state");

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == nbgf_pkg::S_OUT))
		else $error("result raised outside final state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready did not drop after a request");

endmodule

// ----- hw/rtl/nbgf_divroot.sv -----
// Iterative unit: restoring square root or capped scaled division, one bit a cycle.
// Depends on nbgf_pkg.
module nbgf_divroot (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nbgf_pkg::dr_cmd_t             cmd,
	input  logic [nbgf_pkg::WideW-1:0]    num,
	input  logic [nbgf_pkg::WideW-1:0]    den,
	output logic                          busy,
	output logic [nbgf_pkg::WideW-1:0]    res
);

	logic [nbgf_pkg::ShW-1:0]   sh_q;
	logic [nbgf_pkg::WideW-1:0] rem_q, acc_q, den_q;
	logic [nbgf_pkg::CntW-1:0]  cnt_q;
	logic                       root_q;

	logic [nbgf_pkg::WideW-1:0] opa, opb, nrem, qn;
	logic                       ge;

	always_comb begin
		if (root_q) begin
			opa = {rem_q[nbgf_pkg::WideW-3:0], sh_q[nbgf_pkg::ShW-1 -: 2]};
			opb = {acc_q[nbgf_pkg::WideW-3:0], 2'b01};
		end else begin
			opa = {rem_q[nbgf_pkg::WideW-2:0], sh_q[nbgf_pkg::ShW-1]};
			opb = den_q;
		end
		ge   = opa >= opb;
		nrem = ge ? opa - opb : opa;
		qn   = {acc_q[nbgf_pkg::WideW-2:0], ge};
		if (!root_q && qn > nbgf_pkg::QuotCap) begin
			qn = nbgf_pkg::QuotCap;
		end
	end

	assign busy = cnt_q != '0;
	assign res  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			root_q <= 1'b0;
		end else if (cmd.start) begin
			root_q <= cmd.is_root;
			cnt_q  <= cmd.is_root ? nbgf_pkg::CntW'(nbgf_pkg::RootSteps)
			                      : nbgf_pkg::CntW'(nbgf_pkg::DivSteps);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			acc_q <= '0;
			den_q <= den;
			if (cmd.is_root) begin
				sh_q <= {num[nbgf_pkg::DsqW-1:0], {(nbgf_pkg::ShW-nbgf_pkg::DsqW){1'b0}}};
			end else begin
				sh_q <= {num, {nbgf_pkg::FracBits{1'b0}}};
			end
		end else if (busy) begin
			rem_q <= nrem;
			acc_q <= qn;
			sh_q  <= root_q ? {sh_q[nbgf_pkg::ShW-3:0], 2'b00}
			                : {sh_q[nbgf_pkg::ShW-2:0], 1'b0};
		end
	end

endmodule
